FILE: sv/two_source_interference_pixel_defines.svh
// assertion macros used by the top-level rtl
`ifndef TWO_SOURCE_INTERFERENCE_PIXEL_DEFINES_SVH
`define TWO_SOURCE_INTERFERENCE_PIXEL_DEFINES_SVH

// same-cycle implication
`define TSIP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TSIP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/tsip_pkg.sv
package tsip_pkg;

    localparam int COORD_BITS_DEF       = 12;
    localparam int SINE_TABLE_DEPTH_DEF = 1024;
    localparam int FALLOFF_RADIUS_DEF   = 500;

    localparam int CFG_W      = 17;
    localparam int CFG_ADDR_W = 3;
    localparam int CENTER_W   = 14;
    localparam int INV_W      = 17;
    localparam int PITCH_W    = 13;
    localparam int INDEX_W    = 24;
    localparam int GRAY_W     = 8;
    localparam int FRAC_BITS  = 22;

    localparam logic [INV_W-1:0]   INV_RESET   = INV_W'(2048);
    localparam logic [PITCH_W-1:0] PITCH_RESET = PITCH_W'(1024);

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_INV_A   = 3'd0,
        CFG_INV_B   = 3'd1,
        CFG_CA_X    = 3'd2,
        CFG_CA_Y    = 3'd3,
        CFG_CB_X    = 3'd4,
        CFG_CB_Y    = 3'd5,
        CFG_PITCH   = 3'd6,
        CFG_UNUSED  = 3'd7
    } cfg_addr_t;

    // bits of the Q.6 distance, saturated at radius*64
    function automatic int dist_bits(input int radius);
        return $clog2(radius * 64 + 1);
    endfunction

    // sine (16 bit signed) times weight (dist bits plus sign)
    function automatic int term_bits(input int radius);
        return dist_bits(radius) + 17;
    endfunction

    // cycles from input to weighted term
    function automatic int term_latency(input int radius);
        return dist_bits(radius) + 8;
    endfunction

endpackage

FILE: sv/tsip_term.sv
module tsip_term
    import tsip_pkg::*;
#(
    parameter int COORD_BITS       = COORD_BITS_DEF,
    parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF,
    parameter int FALLOFF_RADIUS   = FALLOFF_RADIUS_DEF,
    localparam int TERM_W          = term_bits(FALLOFF_RADIUS)
)
(
    input  logic                     clk,
    input  logic                     en,
    input  logic [COORD_BITS-1:0]    x,
    input  logic [COORD_BITS-1:0]    y,
    input  logic signed [CENTER_W-1:0] cx,
    input  logic signed [CENTER_W-1:0] cy,
    input  logic [INV_W-1:0]         inv,
    output logic signed [TERM_W-1:0] term
);

    localparam int DIST_W = dist_bits(FALLOFF_RADIUS);
    localparam int RAD_W  = 2 * DIST_W;
    localparam int SQ_W   = 32;
    localparam int DX_W   = 16;
    localparam int L      = $clog2(SINE_TABLE_DEPTH);
    localparam int QD     = SINE_TABLE_DEPTH / 4;
    localparam logic [DIST_W-1:0] LIMIT = DIST_W'(FALLOFF_RADIUS * 64);
    localparam logic [SQ_W-1:0]   RSQ   = SQ_W'(FALLOFF_RADIUS * FALLOFF_RADIUS);
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // sin(pi/2 * m / depth) in Q1.14, taylor series as used for the table
    function automatic logic signed [15:0] quarter_sine(input longint unsigned m);
        longint unsigned xv;
        longint unsigned x2;
        longint unsigned t;
        longint          acc;
        longint          r;
        xv  = (HALF_PI_Q30 * m) / SINE_TABLE_DEPTH;
        x2  = (xv * xv) >> 30;
        t   = xv;
        acc = longint'(xv);
        t = ((t * x2) >> 30) / 6;   acc = acc - longint'(t);
        t = ((t * x2) >> 30) / 20;  acc = acc + longint'(t);
        t = ((t * x2) >> 30) / 42;  acc = acc - longint'(t);
        t = ((t * x2) >> 30) / 72;  acc = acc + longint'(t);
        t = ((t * x2) >> 30) / 110; acc = acc - longint'(t);
        t = ((t * x2) >> 30) / 156; acc = acc + longint'(t);
        t = ((t * x2) >> 30) / 210; acc = acc - longint'(t);
        t = ((t * x2) >> 30) / 272; acc = acc + longint'(t);
        if (acc < 0)
            acc = 0;
        r = (acc * 16384 + (longint'(1) << 29)) >>> 30;
        if (r > 16384)
            r = 16384;
        return 16'(r);
    endfunction

    logic signed [15:0] rom [QD+1];

    for (genvar g = 0; g <= QD; g++)
    begin : g_rom
        assign rom[g] = quarter_sine(longint'(4 * g));
    end

    logic signed [DX_W-1:0] dx_reg, dy_reg;
    logic [SQ_W-1:0]        sq_reg;
    logic [RAD_W-1:0]       v_reg   [DIST_W+1];
    logic [RAD_W-1:0]       res_reg [DIST_W+1];
    logic                   sat_reg [DIST_W+1];
    logic [RAD_W-1:0]       v_next   [DIST_W+1];
    logic [RAD_W-1:0]       res_next [DIST_W+1];
    logic [DIST_W-1:0]      dist_reg, wgt1_reg, wgt2_reg, wgt3_reg, wgt4_reg;
    logic [L-1:0]           idx_reg;
    logic [L-2:0]           jj_reg;
    logic                   neg_reg;
    logic signed [15:0]     sin_reg;
    logic signed [TERM_W-1:0] term_reg;
    logic [DIST_W+INV_W-1:0] prod;
    logic [L-3:0]           jlow;
    logic signed [DX_W-1:0] dx_next, dy_next;
    logic signed [SQ_W-1:0] dx2, dy2;

    assign dx_next = $signed({{(DX_W-COORD_BITS){1'b0}}, x}) - DX_W'(cx);
    assign dy_next = $signed({{(DX_W-COORD_BITS){1'b0}}, y}) - DX_W'(cy);
    assign dx2     = SQ_W'(dx_reg) * SQ_W'(dx_reg);
    assign dy2     = SQ_W'(dy_reg) * SQ_W'(dy_reg);
    assign prod    = (DIST_W+INV_W)'(dist_reg) * (DIST_W+INV_W)'(inv);
    assign jlow    = idx_reg[L-3:0];

    // one restoring square-root step per stage
    always_comb
    begin
        v_next[0]   = '0;
        res_next[0] = '0;
        for (int k = 0; k < DIST_W; k++)
        begin
            if (v_reg[k] >= res_reg[k] + (RAD_W'(1) << (2 * (DIST_W - 1 - k))))
            begin
                v_next[k+1]   = v_reg[k] - res_reg[k] - (RAD_W'(1) << (2 * (DIST_W - 1 - k)));
                res_next[k+1] = (res_reg[k] >> 1) + (RAD_W'(1) << (2 * (DIST_W - 1 - k)));
            end
            else
            begin
                v_next[k+1]   = v_reg[k];
                res_next[k+1] = res_reg[k] >> 1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
            sq_reg <= $unsigned(dx2) + $unsigned(dy2);
            sat_reg[0] <= (sq_reg >= RSQ);
            v_reg[0]   <= (sq_reg >= RSQ) ? '0 : {sq_reg[RAD_W-13:0], 12'b0};
            res_reg[0] <= '0;
            for (int k = 1; k <= DIST_W; k++)
            begin
                v_reg[k]   <= v_next[k];
                res_reg[k] <= res_next[k];
                sat_reg[k] <= sat_reg[k-1];
            end
            dist_reg <= sat_reg[DIST_W] ? LIMIT : res_reg[DIST_W][DIST_W-1:0];
            wgt1_reg <= LIMIT - (sat_reg[DIST_W] ? LIMIT : res_reg[DIST_W][DIST_W-1:0]);
            idx_reg  <= prod[FRAC_BITS-1 -: L];
            wgt2_reg <= wgt1_reg;
            // fold the phase onto the quarter table
            jj_reg   <= idx_reg[L-2] ? (L-1)'(QD) - (L-1)'(jlow) : (L-1)'(jlow);
            neg_reg  <= idx_reg[L-1];
            wgt3_reg <= wgt2_reg;
            sin_reg  <= neg_reg ? -rom[jj_reg] : rom[jj_reg];
            wgt4_reg <= wgt3_reg;
            term_reg <= TERM_W'(sin_reg) * TERM_W'($signed({1'b0, wgt4_reg}));
        end
    end

    assign term = term_reg;

endmodule

FILE: sv/two_source_interference_pixel.sv
// two-source interference pixel generator
// s_tdata carries one pixel coordinate, s_tuser says whether the pixel is
// inside the selection. selected pixels come out on the m side as an index
// into the bitmap and an argb word with a gray value; unselected pixels are
// dropped and produce no output transaction.
// the cfg port writes the wave centers, inverse wavelengths and row pitch;
// write it only while no pixel is in flight.
// throughput is one pixel per clock while the output is not stalled. the
// pipeline length depends on dist_bits = clog2(64*FALLOFF_RADIUS+1):
// the square root takes one result bit per stage, the final gray value
// divide by the radius is a reciprocal multiply in one stage.
// the whole pipeline advances together; when m_tready is low while a result
// is waiting, every stage holds and s_tready drops, so nothing is lost.
// reset clears all valid bits and returns the registers to their defaults
// (inverse wavelengths 2048, centers 0, pitch 1024).
`include "two_source_interference_pixel_defines.svh"

module two_source_interference_pixel
    import tsip_pkg::*;
#(
    parameter int COORD_BITS       = COORD_BITS_DEF,
    parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF,
    parameter int FALLOFF_RADIUS   = FALLOFF_RADIUS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [23:0]           s_tdata,  // pixel_x[11:0], pixel_y[23:12]
    input  logic                  s_tuser,  // in_selection
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [55:0]           m_tdata,  // pixel_index[23:0], pixel_word[55:24]
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]      cfg_data
);

    localparam int LT     = term_latency(FALLOFF_RADIUS);
    localparam int TERM_W = term_bits(FALLOFF_RADIUS);
    localparam int LAT    = LT + 3;
    localparam int RW     = $clog2(FALLOFF_RADIUS + 1);
    localparam int ACC_W  = RW + 24;
    localparam int MUL_W  = RW + 31;
    localparam int TW     = RW + 8;
    localparam int K_SH   = 2 * RW + 8;
    localparam int M_W    = RW + 10;
    localparam int PW     = TW + M_W;
    localparam logic signed [ACC_W-1:0] D_CONST = ACC_W'(FALLOFF_RADIUS) << 21;
    // floor(2^K_SH / radius) + 1, exact for every numerator up to 254 * radius
    localparam logic [M_W-1:0]          RECIP   =
        M_W'((64'd1 << K_SH) / FALLOFF_RADIUS + 1);

    logic [INV_W-1:0]           inv_a_reg, inv_b_reg;
    logic signed [CENTER_W-1:0] ca_x_reg, ca_y_reg, cb_x_reg, cb_y_reg;
    logic [PITCH_W-1:0]         pitch_reg;

    logic                     adv;
    logic [COORD_BITS-1:0]    px, py;
    logic [13:0]              px_ext, py_ext;
    logic                     v_reg   [LAT];
    logic [INDEX_W-1:0]       idx_reg [LAT];
    logic signed [TERM_W-1:0] term_a, term_b;
    logic signed [TERM_W:0]   sum_reg;
    logic signed [ACC_W-1:0]  dpos;
    logic [MUL_W-1:0]         n127;
    logic [TW-1:0]            nq_reg;
    logic [PW-1:0]            mul_reg;
    logic [GRAY_W-1:0]        gray;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_a_reg <= INV_RESET;
            inv_b_reg <= INV_RESET;
            ca_x_reg  <= '0;
            ca_y_reg  <= '0;
            cb_x_reg  <= '0;
            cb_y_reg  <= '0;
            pitch_reg <= PITCH_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr_t'(cfg_addr))
                CFG_INV_A: inv_a_reg <= cfg_data;
                CFG_INV_B: inv_b_reg <= cfg_data;
                CFG_CA_X:  ca_x_reg  <= cfg_data[CENTER_W-1:0];
                CFG_CA_Y:  ca_y_reg  <= cfg_data[CENTER_W-1:0];
                CFG_CB_X:  cb_x_reg  <= cfg_data[CENTER_W-1:0];
                CFG_CB_Y:  cb_y_reg  <= cfg_data[CENTER_W-1:0];
                CFG_PITCH: pitch_reg <= cfg_data[PITCH_W-1:0];
                default:   ;
            endcase
        end
    end

    assign adv      = !v_reg[LAT-1] || m_tready;
    assign s_tready = adv;
    assign px_ext   = {2'b00, s_tdata[11:0]};
    assign py_ext   = {2'b00, s_tdata[23:12]};
    assign px       = px_ext[COORD_BITS-1:0];
    assign py       = py_ext[COORD_BITS-1:0];

    tsip_term #(
        .COORD_BITS       (COORD_BITS),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .FALLOFF_RADIUS   (FALLOFF_RADIUS)
    ) u_term_a (
        .clk  (clk),
        .en   (adv),
        .x    (px),
        .y    (py),
        .cx   (ca_x_reg),
        .cy   (ca_y_reg),
        .inv  (inv_a_reg),
        .term (term_a)
    );

    tsip_term #(
        .COORD_BITS       (COORD_BITS),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .FALLOFF_RADIUS   (FALLOFF_RADIUS)
    ) u_term_b (
        .clk  (clk),
        .en   (adv),
        .x    (px),
        .y    (py),
        .cx   (cb_x_reg),
        .cy   (cb_y_reg),
        .inv  (inv_b_reg),
        .term (term_b)
    );

    // 127 * (D + S) >> 21, then divide by the radius with a reciprocal multiply
    assign dpos = ACC_W'(sum_reg) + D_CONST;
    assign n127 = (MUL_W'(dpos) << 7) - MUL_W'(dpos);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAT; i++)
                v_reg[i] <= 1'b0;
        end
        else if (adv)
        begin
            v_reg[0] <= s_tvalid && s_tuser;
            for (int i = 1; i < LAT; i++)
                v_reg[i] <= v_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            idx_reg[0] <= INDEX_W'(px) + INDEX_W'(py) * INDEX_W'(pitch_reg);
            for (int i = 1; i < LAT; i++)
                idx_reg[i] <= idx_reg[i-1];
            sum_reg <= (TERM_W+1)'(term_a) + (TERM_W+1)'(term_b);
            nq_reg  <= n127[21 +: TW];
            mul_reg <= PW'(nq_reg) * PW'(RECIP);
        end
    end

    assign gray     = mul_reg[K_SH +: GRAY_W];
    assign m_tvalid = v_reg[LAT-1];
    assign m_tdata  = {8'hFF, gray, gray, gray, idx_reg[LAT-1]};

    `TSIP_ASSERT_IMP(a_alpha, m_tvalid, m_tdata[55:48] == 8'hFF, "alpha byte not 255")
    `TSIP_ASSERT_IMP(a_gray_eq, m_tvalid, m_tdata[47:24] == {3{m_tdata[31:24]}}, "color bytes differ")
    `TSIP_ASSERT_IMP(a_gray_max, m_tvalid, gray <= 8'd254, "gray above 254")
    `TSIP_ASSERT_NXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid, "result dropped during stall")
    `TSIP_ASSERT_IMP(a_stall_in, m_tvalid && !m_tready, !s_tready, "input taken during stall")

endmodule
